/* rtl/base64_stream_encoder_defines.svh */
// ----------------------------------------------------------------------------
// base64_stream_encoder_defines : assertion macros for the base64 encoder
// Shared property forms for concurrent checks on the clock and reset.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_ENCODER_DEFINES_SVH
`define BASE64_STREAM_ENCODER_DEFINES_SVH

// same-cycle implication
`define B64E_ASSERT_IMPLY(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

// next-cycle implication
`define B64E_ASSERT_NEXT(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`endif

/* rtl/b64e_pkg.sv */
// ----------------------------------------------------------------------------
// b64e_pkg : types and constants of the base64 stream encoder
// Item structs, the group record passed from front to back, symbol mapping.
// ----------------------------------------------------------------------------
package b64e_pkg;

   localparam logic [6:0] PAD_CODE = 7'h3D;
   localparam logic [5:0] SIX_MASK = 6'h3F;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [6:0] char_code;
      logic       last_char;
   } rsp_type;

   // one closed group of up to three bytes, zero-filled
   typedef struct packed {
      logic [23:0] word;
      logic        pad_third;
      logic        pad_fourth;
      logic        fin;
   } group_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // standard alphabet: A-Z a-z 0-9 + /
   function automatic logic [6:0] b64_symbol(input logic [5:0] v);
      logic [6:0] code;
      code = 7'h00;
      case (v) inside
         [6'd0:6'd25]:  code = 7'h41 + {1'b0, v};
         [6'd26:6'd51]: code = 7'h61 + {1'b0, v} - 7'd26;
         [6'd52:6'd61]: code = 7'h30 + {1'b0, v} - 7'd52;
         6'd62:         code = 7'h2B;
         6'd63:         code = 7'h2F;
         default:       code = 7'h00;
      endcase
      return code;
   endfunction

endpackage

/* rtl/base64_stream_encoder.sv */
// ----------------------------------------------------------------------------
// base64_stream_encoder : streaming base64 encoder, padded form
//
//   channel  | handshake        | payload
//   ---------+------------------+-------------------------------------
//   req_     | req_push/full    | data_byte, final_byte (one byte)
//   rsp_     | rsp_pop/empty    | char_code, last_char (one symbol)
//
// Bytes are taken one per cycle while the group queue has room; a byte that
// closes a group (third byte or final flag) is queued as one group record.
// The back end sends one symbol per cycle while the receiver keeps popping,
// four symbols per group.
// Reset is synchronous and empties the queue and the output register.
// A stalled output fills the queue, after which req_full rises.
// ----------------------------------------------------------------------------
`include "base64_stream_encoder_defines.svh"

module base64_stream_encoder import b64e_pkg::*; #(
   parameter int GROUP_QUEUE_DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   queue_status_type q_status;
   logic             q_push, q_pop;
   group_type        q_push_data, q_pop_data;

   b64e_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .q_status (q_status),
      .q_push   (q_push),
      .q_data   (q_push_data)
   );

   b64e_queue #(
      .DEPTH (GROUP_QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .status    (q_status)
   );

   b64e_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_data    (q_pop_data),
      .q_pop     (q_pop),
      .rsp_data  (rsp_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );

   // a final byte always closes its group
   `B64E_ASSERT_IMPLY(a_final_closes, req_push && !req_full && req_data.final_byte, q_push, "final item did not close a group")

   `B64E_ASSERT_IMPLY(a_pop_nonempty, q_pop, !q_status.empty, "group taken from an empty queue")

   // a non-final pad is always followed by the closing pad
   `B64E_ASSERT_NEXT(a_pad_pair, !rsp_empty && rsp_pop && rsp_data.char_code == PAD_CODE && !rsp_data.last_char, !rsp_empty && rsp_data.char_code == PAD_CODE && rsp_data.last_char, "lone pad symbol")

endmodule

/* rtl/b64e_front.sv */
// ----------------------------------------------------------------------------
// b64e_front : byte gatherer
// Collects bytes into groups of up to three, pushing each closed group onward.
// ----------------------------------------------------------------------------
module b64e_front import b64e_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  req_type          req_data,
   output logic             req_full,
   input  queue_status_type q_status,
   output logic             q_push,
   output group_type        q_data
);

   typedef enum logic [1:0] {
      PHASE_ZERO,
      PHASE_ONE,
      PHASE_TWO
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] held_ff, held_in;
   logic        accept;
   logic        closes;

   assign req_full = q_status.full;
   assign accept   = req_push && !q_status.full;

   always_comb begin
      phase_in          = phase_ff;
      held_in           = held_ff;
      closes            = 1'b0;
      q_data.word       = 24'h000000;
      q_data.pad_third  = 1'b0;
      q_data.pad_fourth = 1'b0;
      q_data.fin        = req_data.final_byte;
      case (phase_ff)
         PHASE_ONE: begin
            closes            = req_data.final_byte;
            q_data.word       = {held_ff[15:8], req_data.data_byte, 8'h00};
            q_data.pad_fourth = 1'b1;
            if (accept) begin
               held_in  = {held_ff[15:8], req_data.data_byte};
               phase_in = PHASE_TWO;
            end
         end
         PHASE_TWO: begin
            closes      = 1'b1;
            q_data.word = {held_ff, req_data.data_byte};
         end
         default: begin
            closes            = req_data.final_byte;
            q_data.word       = {req_data.data_byte, 16'h0000};
            q_data.pad_third  = 1'b1;
            q_data.pad_fourth = 1'b1;
            if (accept) begin
               held_in  = {req_data.data_byte, 8'h00};
               phase_in = PHASE_ONE;
            end
         end
      endcase
      if (accept && closes) begin
         held_in  = 16'h0000;
         phase_in = PHASE_ZERO;
      end
   end

   assign q_push = accept && closes;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_ZERO;
         held_ff  <= 16'h0000;
      end else begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

endmodule

/* rtl/b64e_queue.sv */
// ----------------------------------------------------------------------------
// b64e_queue : group queue
// Small circular buffer of closed groups between the front and the back.
// ----------------------------------------------------------------------------
module b64e_queue import b64e_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  group_type        push_data,
   input  logic             pop,
   output group_type        pop_data,
   output queue_status_type status
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   group_type        entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/b64e_back.sv */
// ----------------------------------------------------------------------------
// b64e_back : symbol emitter
// One group at a time: sends its four symbols, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module b64e_back import b64e_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  group_type        q_data,
   output logic             q_pop,
   output rsp_type          rsp_data,
   output logic             rsp_empty,
   input  logic             rsp_pop
);

   localparam logic [1:0] SLOT_FIRST  = 2'd0;
   localparam logic [1:0] SLOT_SECOND = 2'd1;
   localparam logic [1:0] SLOT_THIRD  = 2'd2;
   localparam logic [1:0] SLOT_FOURTH = 2'd3;

   group_type  grp_ff, grp_in;
   logic       busy_ff, busy_in;
   logic [1:0] slot_ff, slot_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;
   logic       out_free;
   logic       advance;
   rsp_type    sym;

   assign out_free = !rsp_valid_ff || rsp_pop;
   assign advance  = busy_ff && out_free;
   assign q_pop    = !q_status.empty && (!busy_ff || (advance && slot_ff == SLOT_FOURTH));

   always_comb begin
      sym.last_char = 1'b0;
      case (slot_ff)
         SLOT_FIRST:  sym.char_code = b64_symbol(grp_ff.word[23:18] & SIX_MASK);
         SLOT_SECOND: sym.char_code = b64_symbol(grp_ff.word[17:12] & SIX_MASK);
         SLOT_THIRD: begin
            sym.char_code = grp_ff.pad_third ? PAD_CODE
                                             : b64_symbol(grp_ff.word[11:6] & SIX_MASK);
         end
         SLOT_FOURTH: begin
            sym.char_code = grp_ff.pad_fourth ? PAD_CODE
                                              : b64_symbol(grp_ff.word[5:0] & SIX_MASK);
            sym.last_char = grp_ff.fin;
         end
         default: sym.char_code = PAD_CODE;
      endcase
   end

   always_comb begin
      grp_in       = grp_ff;
      busy_in      = busy_ff;
      slot_in      = slot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = sym;
         slot_in      = slot_ff + 1'b1;
         if (slot_ff == SLOT_FOURTH) begin
            busy_in = 1'b0;
         end
      end
      if (q_pop) begin
         grp_in  = q_data;
         busy_in = 1'b1;
         slot_in = SLOT_FIRST;
      end
   end

   always_ff @(posedge clock) begin
      grp_ff      <= grp_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         slot_ff      <= SLOT_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_data  = rsp_data_ff;
   assign rsp_empty = !rsp_valid_ff;

endmodule

/* tb/sv/tb_base64_stream_encoder.sv */
// ----------------------------------------------------------------------------
// tb_base64_stream_encoder : self-checking bench for the base64 stream encoder
// Bytes go in through the push/full queue port as short and long messages.
// A local encoder predicts every symbol, and each popped symbol is checked
// in order against it. Sender bursts, receiver stalls and a long output
// hold-off exercise the flow control.
// ----------------------------------------------------------------------------
module tb_base64_stream_encoder;
   import b64e_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 205;
   localparam int HOLD_CYCLES = 150;
   localparam int SETTLE_CYCLES = 16;
   localparam int MAX_REPORTS = 10;
   localparam logic [6:0] PAD_SYMBOL = 7'h3D;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   req_type req_data = '0;
   logic    req_full;
   logic    rsp_empty;
   logic    rsp_pop = 1'b0;
   rsp_type rsp_data;

   // encoder state mirrored by the bench
   logic [15:0] group_bytes = '0;
   logic [1:0]  bytes_in_group = '0;
   rsp_type     pending_symbols[$];

   int error_count = 0;
   int cycle_count = 0;
   int burst_left = 0;
   int hold_left = 0;
   bit hold_req = 1'b0;
   int rx_mode = 0;
   int rx_tick = 0;

   string alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   base64_stream_encoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   function automatic logic [6:0] symbol_code(input logic [5:0] v);
      byte c;
      c = alphabet[v];
      return c[6:0];
   endfunction

   function automatic void push_symbol(input logic [6:0] code, input logic last);
      rsp_type s;
      s.char_code = code;
      s.last_char = last;
      pending_symbols.insert(pending_symbols.size(), s);
   endfunction

   // expected symbols for one accepted byte
   function automatic void encode_byte(input logic [7:0] b, input logic fin);
      logic [23:0] word;
      int          used;
      if (bytes_in_group == 2'd0 || bytes_in_group == 2'd3) begin
         bytes_in_group = 2'd0;
         group_bytes = {b, 8'h00};
      end else if (bytes_in_group == 2'd1) begin
         group_bytes[7:0] = b;
      end
      if (bytes_in_group < 2'd2 && !fin) begin
         bytes_in_group = bytes_in_group + 2'd1;
         return;
      end
      if (bytes_in_group == 2'd2) begin
         word = {group_bytes, b};
         used = 3;
      end else begin
         word = {group_bytes, 8'h00};
         used = bytes_in_group + 1;
      end
      push_symbol(symbol_code(word[23:18]), 1'b0);
      push_symbol(symbol_code(word[17:12]), 1'b0);
      push_symbol(used >= 2 ? symbol_code(word[11:6]) : PAD_SYMBOL, 1'b0);
      push_symbol(used >= 3 ? symbol_code(word[5:0]) : PAD_SYMBOL, fin);
      group_bytes = '0;
      bytes_in_group = '0;
   endfunction

   function automatic void report_error(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("ERROR @%0t: %s", $realtime, msg);
   endfunction

   // one item: bursts of random length separated by random gaps
   task automatic send_byte(input logic [7:0] b, input logic fin);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
         if (gap > 0) begin
            req_push <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_push <= 1'b1;
      req_data <= '{data_byte: b, final_byte: fin};
      do @(posedge clock); while (req_full);
      encode_byte(b, fin);
   endtask

   task automatic send_message(input logic [7:0] msg[$]);
      foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
   endtask

   task automatic drain_output();
      @(negedge clock);
      req_push <= 1'b0;
      while (pending_symbols.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed_groups();
      send_message('{8'h4D});
      send_message('{8'h4D, 8'h61});
      send_message('{8'h4D, 8'h61, 8'h6E});
      send_message('{8'h00, 8'h00, 8'h00});
      send_message('{8'hFF, 8'hFF, 8'hFF});
      // full group of '+' symbols, then a single-byte tail
      send_message('{8'hFB, 8'hEF, 8'hBE, 8'h00});
      send_message('{8'hFF});
      send_message('{8'h00});
      send_message('{8'hFF, 8'h00});
      send_message('{8'h01, 8'h02, 8'h03, 8'h04, 8'h05});
      drain_output();
   endtask

   task automatic test_random_messages();
      logic [7:0] msg[$];
      int         sent;
      int         len;
      logic [7:0] b;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 9);
         msg.delete();
         repeat (len) begin
            case ($urandom_range(0, 9))
               0:       b = 8'h00;
               1:       b = 8'hFF;
               default: b = 8'($urandom_range(0, 255));
            endcase
            msg.insert(msg.size(), b);
         end
         send_message(msg);
         sent += len;
      end
      drain_output();
   endtask

   // output held off while input keeps coming, so the block must stall
   task automatic test_output_backpressure();
      logic [7:0] msg[$];
      repeat (40) msg.insert(msg.size(), 8'($urandom_range(0, 255)));
      @(negedge clock);
      hold_req = 1'b1;
      send_message(msg);
      drain_output();
   endtask

   // receiver: switching stall patterns, plus the long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         rx_tick++;
         if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
         end
         if (rx_tick % 80 == 0) rx_mode = $urandom_range(0, 3);
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            case (rx_mode)
               0:       rsp_pop <= 1'b1;
               1:       rsp_pop <= 1'($urandom_range(0, 1));
               2:       rsp_pop <= (rx_tick % 3 == 0);
               default: rsp_pop <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_symbols.size() == 0) begin
            report_error($sformatf("unexpected symbol code=%02h last=%0b",
                                   rsp_data.char_code, rsp_data.last_char));
         end else begin
            want = pending_symbols.pop_front();
            if (rsp_data.char_code !== want.char_code)
               report_error($sformatf("char_code expected %02h actual %02h",
                                      want.char_code, rsp_data.char_code));
            if (rsp_data.last_char !== want.last_char)
               report_error($sformatf("last_char expected %0b actual %0b",
                                      want.last_char, rsp_data.last_char));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb_base64_stream_encoder failed");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_groups();
      test_output_backpressure();
      test_random_messages();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_symbols.size() == 0) begin
         $display("tb_base64_stream_encoder passed");
      end else begin
         if (pending_symbols.size() != 0)
            $display("%0d expected symbols never arrived", pending_symbols.size());
         $display("tb_base64_stream_encoder failed");
      end
      $finish;
   end

endmodule
